// File: hw/rtl/cags_pkg.sv
// ----------------------------------------------------------------------------
// cags_pkg
// Shared widths, register codes, reset values and types for the cochlear
// gain control smoother.
// ----------------------------------------------------------------------------
package cags_pkg;

  // field widths
  localparam int unsigned SampleW   = 16;  // Q1.15
  localparam int unsigned GainW     = 16;  // Q4.12
  localparam int unsigned WeightW   = 16;  // Q0.16
  localparam int unsigned LevelW    = 18;  // Q3.14
  localparam int unsigned ChanOutW  = 7;
  localparam int unsigned ActiveW   = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // datapath widths
  localparam int unsigned NsumW     = LevelW + 2;            // three levels summed
  localparam int unsigned ProdSW    = SampleW + GainW + 1;   // signed x unsigned
  localparam int unsigned ProdWW    = NsumW + WeightW + 1;
  localparam int unsigned AccW      = ProdWW + 1;
  localparam int unsigned FracDrop  = 16;
  localparam int unsigned QW        = AccW - FracDrop;

  localparam logic signed [AccW-1:0]   RoundHalf = AccW'(32768);
  localparam logic signed [LevelW-1:0] LevelMax  = {1'b0, {(LevelW-1){1'b1}}};
  localparam logic signed [LevelW-1:0] LevelMin  = {1'b1, {(LevelW-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgActive    = 2'd0,
    CfgGain      = 2'd1,
    CfgWeight    = 2'd2,
    CfgCrosstalk = 2'd3
  } cfg_idx_e;

  // reset values
  localparam logic [ActiveW-1:0] ActiveRst    = 8'd128;
  localparam logic [GainW-1:0]   GainRst      = 16'd4096;
  localparam logic [WeightW-1:0] WeightRst    = 16'd21845;
  localparam logic               CrosstalkRst = 1'b1;

  typedef struct packed {
    logic [GainW-1:0]   gain;
    logic [WeightW-1:0] weight;
    logic               crosstalk;
  } cags_coef_t;

endpackage

// File: hw/rtl/cags_level_calc.sv
// ----------------------------------------------------------------------------
// cags_level_calc
// Level update arithmetic: gain*sample + weight*level sum (own, or own plus both neighbours), round, saturate.
// ----------------------------------------------------------------------------
module cags_level_calc (
  input  logic signed [cags_pkg::SampleW-1:0] sample_i,
  input  logic signed [cags_pkg::LevelW-1:0]  left_i,
  input  logic signed [cags_pkg::LevelW-1:0]  own_i,
  input  logic signed [cags_pkg::LevelW-1:0]  right_i,
  input  cags_pkg::cags_coef_t                coef_i,
  output logic signed [cags_pkg::LevelW-1:0]  level_o
);
  import cags_pkg::*;

  logic signed [NsumW-1:0]  nsum;
  logic signed [GainW:0]    gain_s;
  logic signed [WeightW:0]  weight_s;
  logic signed [ProdSW-1:0] prod_s;
  logic signed [ProdWW-1:0] prod_w;
  logic signed [AccW-1:0]   acc;
  logic signed [QW-1:0]     q;
  logic [QW-LevelW:0]       q_top;
  logic                     in_range;

  always_comb begin
    if (coef_i.crosstalk) begin
      nsum = NsumW'(left_i) + NsumW'(own_i) + NsumW'(right_i);
    end else begin
      nsum = NsumW'(own_i);
    end
  end

  assign gain_s   = {1'b0, coef_i.gain};
  assign weight_s = {1'b0, coef_i.weight};
  assign prod_s   = ProdSW'(sample_i) * ProdSW'(gain_s);
  assign prod_w   = ProdWW'(nsum) * ProdWW'(weight_s);

  // gain product is Q.27, lift to Q.30 to line up with the weight product
  assign acc = (AccW'(prod_s) <<< 3) + AccW'(prod_w) + RoundHalf;
  assign q   = acc[AccW-1:FracDrop];  // floor

  // bits above the level's sign must all match it
  assign q_top    = q[QW-1:LevelW-1];
  assign in_range = (q_top == '0) || (q_top == '1);

  always_comb begin
    if (in_range) begin
      level_o = q[LevelW-1:0];
    end else if (q[QW-1]) begin
      level_o = LevelMin;
    end else begin
      level_o = LevelMax;
    end
  end

endmodule

// File: hw/rtl/cags_level_store.sv
// ----------------------------------------------------------------------------
// cags_level_store
// Per-channel level memory: one write port, two registered read ports with
// write-through bypass, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module cags_level_store #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  output logic                               clr_busy_o,
  input  logic                               rd_en_i,
  input  logic [AddrW-1:0]                   rd_addr_own_i,
  input  logic [AddrW-1:0]                   rd_addr_right_i,
  output logic signed [cags_pkg::LevelW-1:0] own_o,
  output logic signed [cags_pkg::LevelW-1:0] right_o,
  input  logic                               wr_en_i,
  input  logic [AddrW-1:0]                   wr_addr_i,
  input  logic signed [cags_pkg::LevelW-1:0] wr_data_i
);
  import cags_pkg::*;

  logic [LevelW-1:0]        mem_q [Depth];
  logic                     clr_q;
  logic [AddrW-1:0]         clr_cnt_q;
  logic signed [LevelW-1:0] own_q;
  logic signed [LevelW-1:0] right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // a write landing on the same edge as the read wins
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      own_q   <= (wr_en_i && (wr_addr_i == rd_addr_own_i)) ? wr_data_i
                                                            : mem_q[rd_addr_own_i];
      right_q <= (wr_en_i && (wr_addr_i == rd_addr_right_i)) ? wr_data_i
                                                              : mem_q[rd_addr_right_i];
    end
  end

  assign clr_busy_o = clr_q;
  assign own_o      = own_q;
  assign right_o    = right_q;

  a_no_access_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !rd_en_i && !wr_en_i)
    else $error("level store accessed during clearing sweep");

endmodule

// File: hw/rtl/cochlear_agc_smoother_core.sv
// ----------------------------------------------------------------------------
// cochlear_agc_smoother_core
// One gain control smoothing stage of a cochlear filterbank, one channel per
// transfer.
// ----------------------------------------------------------------------------
// Usage
//  - Input channel: in_valid_i / in_stall_o with sample_i, the rectified
//    sample of the next channel of the frame, in channel order.
//  - Output channel: out_valid_o / out_stall_i with level_o (new level),
//    channel_o (index within frame) and frame_end_o (last channel).
//  - A transfer happens on a rising edge with valid high and stall low.
//  - Config: cfg_we_i, cfg_index_i, cfg_wdata_i; write only while idle.
//  - Pipeline: input/read-data register, then result register; the result
//    register is loaded as an item leaves the input stage.
//  - Throughput: one item per cycle, sustained while the receiver does not
//    stall; set by the two-read, one-write level memory, which is read as
//    an item is taken in and written as it moves into the result register.
//  - Reset: registers take their reset values, the channel counter returns
//    to channel 0 and the level memory is swept to zero, one entry per cycle,
//    through all MAX_CHANNELS entries; in_stall_o is held high meanwhile.
//  - Receiver stall: the result register holds; the input stage keeps one
//    item, and in_stall_o rises only once that stage is full too.
// ----------------------------------------------------------------------------
module cochlear_agc_smoother_core #(
  parameter int unsigned MAX_CHANNELS = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [cags_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [cags_pkg::CfgDataW-1:0]        cfg_wdata_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [cags_pkg::SampleW-1:0]  sample_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [cags_pkg::LevelW-1:0]   level_o,
  output logic [cags_pkg::ChanOutW-1:0]        channel_o,
  output logic                                 frame_end_o
);
  import cags_pkg::*;

  localparam int unsigned AddrW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CntW  = AddrW + 1;
  localparam int unsigned NW    = (CntW > ActiveW) ? CntW : ActiveW;

  // configuration registers
  logic [ActiveW-1:0] active_q;
  cags_coef_t         coef_q;

  // channel sequencing
  logic [AddrW-1:0]   cnt_q;
  logic [NW-1:0]      act_x;
  logic [NW-1:0]      frame_n;
  logic [AddrW-1:0]   cur_ch;
  logic               cur_last;
  logic [AddrW-1:0]   right_addr;

  // handshake
  logic               in_acc;
  logic               out_free;
  logic               s1_adv;
  logic               clr_busy;

  // input stage
  logic                     s1_v_q;
  logic signed [SampleW-1:0] sample_q;
  logic [AddrW-1:0]         s1_ch_q;
  logic                     s1_last_q;
  logic                     s1_first_q;
  logic signed [LevelW-1:0] left_old_q;

  // memory data and the new level
  logic signed [LevelW-1:0] own_rd;
  logic signed [LevelW-1:0] right_rd;
  logic signed [LevelW-1:0] left_sel;
  logic signed [LevelW-1:0] level_new;

  // result register
  logic                     out_v_q;
  logic signed [LevelW-1:0] level_q;
  logic [ChanOutW-1:0]      chan_q;
  logic                     fend_q;

  // -- configuration -------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q         <= ActiveRst;
      coef_q.gain      <= GainRst;
      coef_q.weight    <= WeightRst;
      coef_q.crosstalk <= CrosstalkRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgActive:    active_q         <= cfg_wdata_i[ActiveW-1:0];
        CfgGain:      coef_q.gain      <= cfg_wdata_i[GainW-1:0];
        CfgWeight:    coef_q.weight    <= cfg_wdata_i[WeightW-1:0];
        CfgCrosstalk: coef_q.crosstalk <= cfg_wdata_i[0];
        default:      ;
      endcase
    end
  end

  // -- frame length and current channel -----------------------------------
  // zero counts as one, anything beyond the memory clamps to its depth
  assign act_x = NW'(active_q);

  always_comb begin
    if (active_q == '0) begin
      frame_n = NW'(1);
    end else if (act_x > NW'(MAX_CHANNELS)) begin
      frame_n = NW'(MAX_CHANNELS);
    end else begin
      frame_n = act_x;
    end
  end

  // a shrunk frame restarts at channel 0
  assign cur_ch     = (NW'(cnt_q) >= frame_n) ? '0 : cnt_q;
  assign cur_last   = (NW'(cur_ch) + NW'(1)) == frame_n;
  // last channel uses its own level as right neighbour
  assign right_addr = cur_last ? cur_ch : cur_ch + AddrW'(1);

  // -- handshake -----------------------------------------------------------
  assign out_free   = !out_v_q || !out_stall_i;
  assign s1_adv     = s1_v_q && out_free;
  assign in_stall_o = clr_busy || (s1_v_q && !out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // -- input stage ---------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      cnt_q      <= '0;
      s1_ch_q    <= '0;
      s1_last_q  <= 1'b0;
      s1_first_q <= 1'b0;
      left_old_q <= '0;
    end else begin
      if (in_acc) begin
        s1_v_q     <= 1'b1;
        s1_ch_q    <= cur_ch;
        s1_last_q  <= cur_last;
        s1_first_q <= (cur_ch == '0);
        cnt_q      <= cur_last ? '0 : cur_ch + AddrW'(1);
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      // pre-update level of this channel becomes the next one's left
      if (s1_adv) begin
        left_old_q <= own_rd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
    end
  end

  cags_level_store #(
    .Depth (MAX_CHANNELS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clr_busy_o      (clr_busy),
    .rd_en_i         (in_acc),
    .rd_addr_own_i   (cur_ch),
    .rd_addr_right_i (right_addr),
    .own_o           (own_rd),
    .right_o         (right_rd),
    .wr_en_i         (s1_adv),
    .wr_addr_i       (s1_ch_q),
    .wr_data_i       (level_new)
  );

  // first channel uses its own level as left neighbour
  assign left_sel = s1_first_q ? own_rd : left_old_q;

  cags_level_calc u_calc (
    .sample_i (sample_q),
    .left_i   (left_sel),
    .own_i    (own_rd),
    .right_i  (right_rd),
    .coef_i   (coef_q),
    .level_o  (level_new)
  );

  // -- result register -----------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      level_q <= level_new;
      chan_q  <= ChanOutW'(s1_ch_q);
      fend_q  <= s1_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign level_o     = level_q;
  assign channel_o   = chan_q;
  assign frame_end_o = fend_q;

  // -- checks --------------------------------------------------------------
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !s1_v_q || s1_adv)
    else $error("input stage overwritten while occupied");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s1_adv |=> s1_v_q && $stable(s1_ch_q) && $stable(sample_q))
    else $error("held input stage changed");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cur_last |=> cnt_q == '0)
    else $error("channel counter did not wrap after last channel");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cochlear gain control smoother. A predictor
// keeps its own copy of the level memory, channel counter and registers,
// works out the level, channel and frame flag of every input transfer, and a
// monitor compares each output transfer with the oldest outstanding one.
// ----------------------------------------------------------------------------
module tb_top;
  import cags_pkg::*;

  localparam int unsigned NumChan     = 128;
  localparam int unsigned ReportCap   = 30;     // mismatch lines printed before going quiet
  localparam int unsigned RandomItems = 1700;
  localparam int unsigned DrainGuard  = 4000;   // cycles allowed for outstanding levels
  localparam int unsigned SettleCyc   = 4;      // extra wait once no level is outstanding

  // one expected output transfer
  typedef struct {
    logic signed [LevelW-1:0] level;
    logic [ChanOutW-1:0]      chan;
    logic                     last_chan;
  } level_rec_t;

  typedef enum int unsigned {RxFlow, RxLight, RxHeavy, RxPeriodic} rx_mode_e;

  // --------------------------------------------------------------------------
  // Level predictor and store of expected levels
  // --------------------------------------------------------------------------
  class level_tracker;
    logic [ActiveW-1:0]       n_active;
    logic [GainW-1:0]         gain;
    logic [WeightW-1:0]       weight;
    logic                     xtalk;
    logic signed [LevelW-1:0] level_mem [NumChan];
    int unsigned              chan_ptr;
    logic signed [LevelW-1:0] prev_own;     // pre-update level of the previous channel
    level_rec_t               expected_levels[$];
    int unsigned              err_count;
    int unsigned              checked;
    int unsigned              frames;
    int unsigned              saturated;

    function new();
      n_active  = ActiveRst;
      gain      = GainRst;
      weight    = WeightRst;
      xtalk     = CrosstalkRst;
      foreach (level_mem[i]) level_mem[i] = '0;
      chan_ptr  = 0;
      prev_own  = '0;
      err_count = 0;
      checked   = 0;
      frames    = 0;
      saturated = 0;
    endfunction

    function void report(string msg);
      if (err_count < ReportCap) $display("[%0t] MISMATCH: %s", $time, msg);
      err_count++;
    endfunction

    function int unsigned pending();
      return expected_levels.size();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgActive:    n_active = val[ActiveW-1:0];
        CfgGain:      gain     = val[GainW-1:0];
        CfgWeight:    weight   = val[WeightW-1:0];
        CfgCrosstalk: xtalk    = val[0];
        default: ;
      endcase
    endfunction

    // one accepted sample: update the level memory and queue the result
    function void note_sample(logic signed [SampleW-1:0] s);
      int unsigned              n;
      int unsigned              c;
      bit                       last_chan;
      logic signed [LevelW-1:0] own;
      logic signed [LevelW-1:0] lft;
      logic signed [LevelW-1:0] rgt;
      longint                   nsum;
      longint                   acc;
      longint                   q;
      level_rec_t               rec;
      n = n_active;
      if (n == 0) n = 1;
      if (n > NumChan) n = NumChan;
      c = chan_ptr;
      if (c >= n) c = 0;                     // count shrunk mid frame
      last_chan = (c + 1 == n);
      own = level_mem[c];
      lft = (c == 0) ? own : prev_own;       // edge channels mirror themselves
      rgt = last_chan ? own : level_mem[c + 1];
      if (xtalk) nsum = longint'(lft) + longint'(own) + longint'(rgt);
      else       nsum = longint'(own);
      acc = longint'(s) * longint'(gain) * 8 + nsum * longint'(weight);
      q = (acc + 32768) >>> 16;              // round half up, floor
      if (q > longint'(LevelMax)) q = longint'(LevelMax);
      if (q < longint'(LevelMin)) q = longint'(LevelMin);
      level_mem[c] = q[LevelW-1:0];
      prev_own     = own;
      chan_ptr     = last_chan ? 0 : c + 1;
      rec.level     = q[LevelW-1:0];
      rec.chan      = c[ChanOutW-1:0];
      rec.last_chan = last_chan;
      expected_levels.push_back(rec);
    endfunction

    function void check_level(logic signed [LevelW-1:0] lvl, logic [ChanOutW-1:0] ch,
                              logic fe);
      level_rec_t exp_rec;
      if (expected_levels.size() == 0) begin
        report($sformatf("unexpected level %0d on channel %0d", lvl, ch));
        return;
      end
      exp_rec = expected_levels.pop_front();
      checked++;
      if (lvl !== exp_rec.level)
        report($sformatf("ch %0d level %0d, predicted %0d", exp_rec.chan, lvl, exp_rec.level));
      if (ch !== exp_rec.chan)
        report($sformatf("channel %0d, predicted %0d", ch, exp_rec.chan));
      if (fe !== exp_rec.last_chan)
        report($sformatf("ch %0d frame_end %b, predicted %b", exp_rec.chan, fe,
                         exp_rec.last_chan));
      if (exp_rec.last_chan) frames++;
      if (exp_rec.level == LevelMax || exp_rec.level == LevelMin) saturated++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block signals; every input known from time zero
  // --------------------------------------------------------------------------
  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  cfg_idx_e                   cfg_index = CfgActive;
  logic [CfgDataW-1:0]        cfg_wdata = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic signed [SampleW-1:0]  sample    = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [LevelW-1:0]   level;
  logic [ChanOutW-1:0]        channel;
  logic                       frame_end;

  level_tracker sb;
  int unsigned  burst_left = 0;
  int unsigned  phases     = 0;
  int unsigned  sent       = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cochlear_agc_smoother_core #(
    .MAX_CHANNELS(NumChan)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .level_o     (level),
    .channel_o   (channel),
    .frame_end_o (frame_end)
  );

  // --------------------------------------------------------------------------
  // Monitors: both sides sampled at the edge, pre-edge values.
  // Input noted before output so a same-edge result still finds its entry.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (in_valid && !in_stall) sb.note_sample(sample);
    if (out_valid && !out_stall) sb.check_level(level, channel, frame_end);
  end

  // --------------------------------------------------------------------------
  // Receiver: switches between free flow, light and heavy random stall and a
  // periodic pattern (stalled while the phase counter modulo 16 is below 11).
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode  = RxFlow;
  int unsigned rx_left  = 0;
  int unsigned rx_phase = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 3));
      rx_left  = $urandom_range(20, 300);
      rx_phase = 0;
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RxFlow:  out_stall <= 1'b0;
      RxLight: out_stall <= ($urandom_range(0, 3) == 0);
      RxHeavy: out_stall <= ($urandom_range(0, 4) != 0);
      default: out_stall <= ((rx_phase % 16) < 11);
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  // present one sample and hold it until the transfer happens
  task automatic send_sample(input logic signed [SampleW-1:0] s);
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // bursts of random length; a quarter of bursts follow on with no gap
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // stop sending and wait for every outstanding level, then let the pipe empty
  task automatic settle_levels();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && guard < DrainGuard) begin
      @(posedge clk);
      guard++;
    end
    repeat (SettleCyc) @(posedge clk);
  endtask

  // write all four registers back to back; we only drops after the last one
  task automatic program_regs(input logic [CfgDataW-1:0] act, input logic [CfgDataW-1:0] gn,
                              input logic [CfgDataW-1:0] wt, input logic [CfgDataW-1:0] xt);
    cfg_we    <= 1'b1;
    cfg_index <= CfgActive;
    cfg_wdata <= act;
    @(posedge clk);
    sb.set_reg(CfgActive, act);
    cfg_index <= CfgGain;
    cfg_wdata <= gn;
    @(posedge clk);
    sb.set_reg(CfgGain, gn);
    cfg_index <= CfgWeight;
    cfg_wdata <= wt;
    @(posedge clk);
    sb.set_reg(CfgWeight, wt);
    cfg_index <= CfgCrosstalk;
    cfg_wdata <= xt;
    @(posedge clk);
    sb.set_reg(CfgCrosstalk, xt);
    cfg_we <= 1'b0;
    phases++;
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return SampleW'($urandom());
    endcase
  endfunction

  // mostly short frames; zero, full and oversized counts now and then.
  // Upper byte is junk, the register keeps the low eight bits.
  function automatic logic [CfgDataW-1:0] pick_active();
    logic [ActiveW-1:0] n;
    case ($urandom_range(0, 9))
      0:       n = '0;
      1:       n = 8'd128;
      2:       n = ActiveW'($urandom_range(129, 255));
      3, 4:    n = ActiveW'($urandom_range(1, 4));
      default: n = ActiveW'($urandom_range(2, 24));
    endcase
    return {8'($urandom()), n};
  endfunction

  function automatic logic [CfgDataW-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3:    return CfgDataW'($urandom());
      default: return CfgDataW'($urandom_range(0, 8192));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return WeightRst;
      3:       return CfgDataW'($urandom());
      default: return CfgDataW'($urandom_range(0, 32768));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned          rand_sent;
    int unsigned          len;
    logic [CfgDataW-1:0]  xt;
    rand_sent = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, 128 channels. First transfer waits out the memory sweep.
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    settle_levels();

    // Counter sits at channel 7, frame shrinks to 3: restart at channel 0.
    // Full gain and weight drive both rails.
    program_regs(16'h0003, 16'hFFFF, 16'hFFFF, 16'h0001);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    settle_levels();

    // zero count behaves as one channel; own level only, zero gain
    program_regs(16'hAB00, 16'h0000, 16'hFFFF, 16'hFFFE);
    send_sample(16'sh7FFF);
    send_sample(16'sh1234);
    send_sample(16'sh8000);
    settle_levels();

    // oversized count clamps to 128; zero weight passes only the sample term
    program_regs(16'h00C8, GainRst, 16'h0000, 16'h0001);
    send_sample(16'sh4000);
    send_sample(16'shC000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    settle_levels();

    // single channel with crosstalk: both neighbours are its own level
    program_regs(16'h0001, GainRst, WeightRst, 16'h0001);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh0100);
    settle_levels();

    // Random phases: fresh settings each time, frame usually left mid way so
    // the next count may cut it short.
    while (rand_sent < RandomItems) begin
      xt = CfgDataW'($urandom());
      program_regs(pick_active(), pick_gain(), pick_weight(), xt);
      len = $urandom_range(10, 150);
      repeat (len) begin
        pace_sender();
        send_sample(pick_sample());
        rand_sent++;
        // occasional full drain with no register change
        if ($urandom_range(0, 199) == 0) settle_levels();
      end
      settle_levels();
    end

    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted levels never arrived", sb.pending()));

    $display("Summary: %0d samples sent, %0d levels checked, %0d frames closed, %0d saturated",
             sent, sb.checked, sb.frames, sb.saturated);
    $display("Summary: %0d register settings incl. zero/oversized counts, crosstalk on and off",
             phases);
    if (sb.err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", sb.err_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Run timed out");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/cags_pkg.sv
hw/rtl/cags_level_calc.sv
hw/rtl/cags_level_store.sv
hw/rtl/cochlear_agc_smoother_core.sv
dv/tb_top.sv
